### rtl/qau_pkg.sv
// Shared types, character codes and the hex digit decoder for the argument unescaper.
`default_nettype none

package qau_pkg;

    // Result kinds
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_CHAR = 2'd0;
    localparam kind_t KIND_DONE = 2'd1;
    localparam kind_t KIND_ERR  = 2'd2;

    // Characters the decoder reacts to
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // Decoded hex digit: valid flag and nibble value
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    // Map an ASCII hex digit of either case to its value
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.valid = 1'b0;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d.valid = 1'b1;
            d.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d.valid = 1'b1;
            d.value = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d.valid = 1'b1;
            d.value = 4'(c - 8'h37);
        end
        return d;
    endfunction

endpackage

`default_nettype wire

### rtl/quoted_argument_unescaper.sv
// Streaming decoder for one quoted or plain command argument, one byte per item.
//
// Usage: input bytes arrive on the s_* stream, one argument byte per item. The
// first byte picks the mode (a double quote opens a quoted argument). Each
// decoded character leaves on the m_* stream with kind CHAR; the end of the
// argument gives one DONE item carrying the consumed byte count and decoded
// length, and a malformed escape, bad hex digit or missing close quote gives
// one ERR item. After DONE or ERR the decoder is idle for the next argument.
// Bytes that only advance the parse (opening or closing quote, backslash, x,
// first hex digit) give no output item; the byte after a closing quote always
// gives DONE.
// Throughput: one item per cycle while s_tready is high; the decode state
// machine updates in the cycle an item is accepted. A result is held in the
// output register, or in the skid stage while the output register waits.
// Stall: an output register plus skid stage (two entries) keeps s_tready high
// while one result waits; s_tready drops only when both entries are full.
// Reset: rst_n clears the parse state and empties both output entries.
`default_nettype none

module quoted_argument_unescaper #(
    parameter int MAX_CHARS = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] out_byte, [17:8] consumed, [25:18] length
    output logic [1:0]       m_tuser    // [1:0] kind
);

    localparam int CW  = $clog2(MAX_CHARS + 1);
    localparam int BW  = $clog2(4 * MAX_CHARS + 4);
    localparam int CWX = (CW > 8) ? CW : 8;
    localparam int BWX = (BW > 10) ? BW : 10;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_BODY   = 3'd1;
    localparam logic [2:0] PH_ESC    = 3'd2;
    localparam logic [2:0] PH_HEX1   = 3'd3;
    localparam logic [2:0] PH_HEX2   = 3'd4;
    localparam logic [2:0] PH_AFTERQ = 3'd5;

    typedef struct packed {
        logic [7:0]    length;
        logic [9:0]    consumed;
        logic [7:0]    out_byte;
        qau_pkg::kind_t kind;
    } result_t;

    logic [2:0]    phase_reg, phase_next;
    logic          quoted_reg, quoted_next;
    logic [3:0]    hex_hi_reg, hex_hi_next;
    logic [CW-1:0] char_count_reg, char_count_next;
    logic [BW-1:0] byte_count_reg, byte_count_next;

    logic          out_valid_reg, out_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    result_t       out_reg, out_next;
    result_t       skid_reg, skid_next;

    logic          in_fire;
    logic          res_valid;
    result_t       res;
    logic [7:0]    c;
    qau_pkg::hex_digit_t hex_d;

    assign c        = s_tdata;
    assign hex_d    = qau_pkg::hex_decode(c);
    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;

    // Decode one byte: next parse state and at most one result
    always_comb
    begin
        logic          q_eff;
        logic          at_end;
        logic          do_char;
        logic          do_done;
        logic          do_err;
        logic [7:0]    ch;
        logic [CWX-1:0] cc_ext;
        logic [BWX-1:0] bc_ext;

        phase_next      = phase_reg;
        quoted_next     = quoted_reg;
        hex_hi_next     = hex_hi_reg;
        char_count_next = char_count_reg;
        byte_count_next = byte_count_reg;
        do_char = 1'b0;
        do_done = 1'b0;
        do_err  = 1'b0;
        ch      = 8'd0;
        q_eff   = quoted_reg;
        at_end  = 1'b0;
        cc_ext  = '0;
        bc_ext  = '0;

        unique case (phase_reg)
            PH_IDLE, PH_BODY:
            begin
                phase_next = PH_BODY;
                if (phase_reg == PH_IDLE && c == qau_pkg::CH_QUOTE)
                begin
                    quoted_next     = 1'b1;
                    byte_count_next = BW'(1);
                end
                else
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        q_eff       = 1'b0;
                        quoted_next = 1'b0;
                    end
                    at_end = (char_count_reg >= CW'(MAX_CHARS)) || (c == qau_pkg::CH_NUL) ||
                             (q_eff ? (c == qau_pkg::CH_QUOTE) : (c == qau_pkg::CH_COMMA));
                    if (at_end)
                    begin
                        if (q_eff)
                        begin
                            if (c != qau_pkg::CH_QUOTE)
                                do_err = 1'b1;
                            else
                            begin
                                byte_count_next = byte_count_reg + BW'(1);
                                phase_next      = PH_AFTERQ;
                            end
                        end
                        else
                        begin
                            if (c == qau_pkg::CH_COMMA)
                                byte_count_next = byte_count_reg + BW'(1);
                            do_done = 1'b1;
                        end
                    end
                    else if (c == qau_pkg::CH_BSL)
                    begin
                        byte_count_next = byte_count_reg + BW'(1);
                        phase_next      = PH_ESC;
                    end
                    else
                    begin
                        do_char = 1'b1;
                        ch      = c;
                    end
                end
            end
            PH_ESC:
            begin
                phase_next = PH_BODY;
                unique case (c)
                    qau_pkg::CH_N:     begin do_char = 1'b1; ch = qau_pkg::CH_LF;  end
                    qau_pkg::CH_R:     begin do_char = 1'b1; ch = qau_pkg::CH_CR;  end
                    qau_pkg::CH_T:     begin do_char = 1'b1; ch = qau_pkg::CH_TAB; end
                    qau_pkg::CH_QUOTE: begin do_char = 1'b1; ch = qau_pkg::CH_QUOTE; end
                    qau_pkg::CH_BSL:   begin do_char = 1'b1; ch = qau_pkg::CH_BSL; end
                    qau_pkg::CH_X:
                    begin
                        byte_count_next = byte_count_reg + BW'(1);
                        phase_next      = PH_HEX1;
                    end
                    default:           do_err = 1'b1;
                endcase
            end
            PH_HEX1:
            begin
                if (!hex_d.valid)
                    do_err = 1'b1;
                else
                begin
                    hex_hi_next     = hex_d.value;
                    byte_count_next = byte_count_reg + BW'(1);
                    phase_next      = PH_HEX2;
                end
            end
            PH_HEX2:
            begin
                phase_next = PH_BODY;
                if (!hex_d.valid)
                    do_err = 1'b1;
                else
                begin
                    do_char = 1'b1;
                    ch      = {hex_hi_reg, hex_d.value};
                end
            end
            PH_AFTERQ:
            begin
                if (c == qau_pkg::CH_COMMA)
                    byte_count_next = byte_count_reg + BW'(1);
                do_done = 1'b1;
            end
            default:
            begin
                phase_next      = PH_IDLE;
                quoted_next     = 1'b0;
                hex_hi_next     = 4'd0;
                char_count_next = '0;
                byte_count_next = '0;
            end
        endcase

        // Count an emitted character
        if (do_char)
        begin
            char_count_next = char_count_reg + CW'(1);
            byte_count_next = byte_count_reg + BW'(1);
        end

        // Saturate the reported counts to their field widths
        cc_ext = CWX'(char_count_reg);
        bc_ext = BWX'(byte_count_next);

        res_valid    = do_char || do_done || do_err;
        res.kind     = do_done ? qau_pkg::KIND_DONE :
                       (do_err ? qau_pkg::KIND_ERR : qau_pkg::KIND_CHAR);
        res.out_byte = do_char ? ch : 8'd0;
        res.consumed = do_done ? ((bc_ext > BWX'(1023)) ? 10'h3FF : bc_ext[9:0]) : 10'd0;
        res.length   = do_done ? ((cc_ext > CWX'(255)) ? 8'hFF : cc_ext[7:0]) : 8'd0;

        // Drop back to idle after the argument ends or on an error
        if (do_done || do_err)
        begin
            phase_next      = PH_IDLE;
            quoted_next     = 1'b0;
            hex_hi_next     = 4'd0;
            char_count_next = '0;
            byte_count_next = '0;
        end
    end

    // Parse state advances only on an accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            quoted_reg     <= 1'b0;
            hex_hi_reg     <= 4'd0;
            char_count_reg <= '0;
            byte_count_reg <= '0;
        end
        else if (in_fire)
        begin
            phase_reg      <= phase_next;
            quoted_reg     <= quoted_next;
            hex_hi_reg     <= hex_hi_next;
            char_count_reg <= char_count_next;
            byte_count_reg <= byte_count_next;
        end
    end

    // Output register with skid stage
    always_comb
    begin
        logic out_free;
        out_free        = !out_valid_reg || m_tready;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
                if (in_fire && res_valid)
                begin
                    skid_next       = res;
                    skid_valid_next = 1'b1;
                end
            end
            else
            begin
                out_next       = res;
                out_valid_next = in_fire && res_valid;
            end
        end
        else if (in_fire && res_valid)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {6'd0, out_reg.length, out_reg.consumed, out_reg.out_byte};

`ifndef ASSERT_OFF
    // Skid entry is only used behind a waiting output entry
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output entry empty");

    // Character count never passes the limit
    a_char_limit: assert property (@(posedge clk) disable iff (!rst_n)
        char_count_reg <= CW'(MAX_CHARS))
        else $error("character count beyond limit");

    // Character results carry no counts, and no unused kind appears
    a_char_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == qau_pkg::KIND_CHAR && m_tdata[25:8] == 18'd0) ||
                      (m_tuser == qau_pkg::KIND_DONE && m_tdata[7:0] == 8'd0) ||
                      (m_tuser == qau_pkg::KIND_ERR && m_tdata[25:0] == 26'd0)))
        else $error("result fields inconsistent with kind");
`endif

endmodule

`default_nettype wire
